/* sv/rmq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int DATA_W        = 16;
	localparam int MAG_W         = 17;
	localparam int QUO_W         = 16;

	// axis / lane targets: 0..2 are x, y, z and 3 is w
	localparam logic [1:0] TGT_X = 2'd0;
	localparam logic [1:0] TGT_Y = 2'd1;
	localparam logic [1:0] TGT_Z = 2'd2;
	localparam logic [1:0] TGT_W = 2'd3;

	// information that rides alongside the radicand and root
	typedef struct packed {
		logic                        degen;
		logic [1:0]                  root_tgt;
		logic [2:0][1:0]             tgt;
		logic [2:0]                  neg;
		logic [2:0][MAG_W-1:0]       mag;
	} side_t;

	// width of a positive radicand
	function automatic int rad_bits(input int f);
		return ((f > 17) ? f : 17) + 1;
	endfunction

	// width of the root of radicand << f
	function automatic int sqrt_bits(input int f);
		return (rad_bits(f) + f + 1) / 2;
	endfunction

endpackage
`default_nettype wire

/* sv/rmq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface rmq_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		input ready);
	modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		output ready);
endinterface

interface rmq_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic               degenerate;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, degenerate,
		input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, degenerate,
		output ready);
endinterface
`default_nettype wire

/* sv/rmq_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmq_prep
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [2:0][2:0][DATA_W-1:0] m,
	output logic                               valid_s1,
	output logic [rad_bits(FRAC_BITS)-1:0]     rad_s1,
	output side_t                              side_s1
);
	localparam int RB = rad_bits(FRAC_BITS);
	localparam int PW = RB + 2;

	logic signed [DATA_W-1:0] e [3][3];
	logic signed [PW-1:0] one_w, trace, rad_tr, rad_el;
	logic        [1:0]    ai, aj, ak;
	logic                 tr_pos, degen;
	logic signed [17:0]   d [3];
	side_t                side;

	// element selects of a packed array are unsigned, so re-sign them
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				e[r][c] = $signed(m[r][c]);
			end
		end
	end

	always_comb begin
		one_w  = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
		trace  = PW'(e[0][0]) + PW'(e[1][1]) + PW'(e[2][2]);
		tr_pos = trace > 0;
		rad_tr = trace + one_w;
		if (e[0][0] < e[1][1]) begin
			ai = (e[1][1] < e[2][2]) ? 2'd2 : 2'd1;
		end else begin
			ai = (e[0][0] < e[2][2]) ? 2'd2 : 2'd0;
		end
		case (ai)
			2'd0:    begin aj = 2'd1; ak = 2'd2; end
			2'd1:    begin aj = 2'd2; ak = 2'd0; end
			default: begin aj = 2'd0; ak = 2'd1; end
		endcase
		rad_el = PW'(e[ai][ai]) - PW'(e[aj][aj]) - PW'(e[ak][ak]) + one_w;
		degen  = !tr_pos && (rad_el <= 0);

		if (tr_pos) begin
			d[0] = 18'(e[2][1]) - 18'(e[1][2]);
			d[1] = 18'(e[0][2]) - 18'(e[2][0]);
			d[2] = 18'(e[1][0]) - 18'(e[0][1]);
			side.root_tgt = TGT_W;
			side.tgt[0]   = TGT_X;
			side.tgt[1]   = TGT_Y;
			side.tgt[2]   = TGT_Z;
		end else begin
			d[0] = 18'(e[ak][aj]) - 18'(e[aj][ak]);
			d[1] = 18'(e[aj][ai]) + 18'(e[ai][aj]);
			d[2] = 18'(e[ak][ai]) + 18'(e[ai][ak]);
			side.root_tgt = ai;
			side.tgt[0]   = TGT_W;
			side.tgt[1]   = aj;
			side.tgt[2]   = ak;
		end
		side.degen = degen;
		for (int l = 0; l < 3; l++) begin
			side.neg[l] = d[l][17];
			side.mag[l] = d[l][17] ? MAG_W'(-d[l]) : MAG_W'(d[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// degenerate items carry a dummy radicand so the root stays nonzero
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= degen ? RB'(1) : (tr_pos ? RB'(rad_tr) : RB'(rad_el));
			side_s1 <= side;
		end
	end
endmodule
`default_nettype wire

/* sv/rmq_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [rad_bits(FRAC_BITS)-1:0] rad,
	input  wire side_t                         in_side,
	output logic                               out_valid,
	output logic [sqrt_bits(FRAC_BITS)-1:0]    root,
	output side_t                              out_side
);
	localparam int SB  = sqrt_bits(FRAC_BITS);
	localparam int RW  = 2 * SB;
	localparam int RMW = SB + 3;

	logic [RW-1:0]  arg_s  [SB+1];
	logic [RMW-1:0] rem_s  [SB+1];
	logic [SB-1:0]  root_s [SB+1];
	logic           vld_s  [SB+1];
	side_t          side_s [SB+1];

	// entry point: radicand scaled by one
	always_comb begin
		arg_s[0]  = RW'(rad) << FRAC_BITS;
		rem_s[0]  = '0;
		root_s[0] = '0;
		vld_s[0]  = in_valid;
		side_s[0] = in_side;
	end

	// one root bit per stage
	for (genvar k = 0; k < SB; k++) begin : g_stage
		logic [RMW-1:0] t, trial;
		always_comb begin
			t     = {rem_s[k][RMW-3:0], arg_s[k][RW-1 -: 2]};
			trial = RMW'({root_s[k], 2'b01});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				arg_s[k+1]  <= arg_s[k] << 2;
				side_s[k+1] <= side_s[k];
				if (t >= trial) begin
					rem_s[k+1]  <= t - trial;
					root_s[k+1] <= {root_s[k][SB-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= t;
					root_s[k+1] <= {root_s[k][SB-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[SB];
	assign root      = root_s[SB];
	assign out_side  = side_s[SB];
endmodule
`default_nettype wire

/* sv/rmq_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module rmq_div
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [sqrt_bits(FRAC_BITS)-1:0] root,
	input  wire side_t                         in_side,
	output logic                               out_valid,
	output logic [2:0][QUO_W-1:0]              quo,
	output logic [2:0]                         ovf,
	output logic [sqrt_bits(FRAC_BITS)-1:0]    out_root,
	output side_t                              out_side
);
	localparam int SB = sqrt_bits(FRAC_BITS);
	localparam int NB = MAG_W + FRAC_BITS + 1;
	localparam int W  = ((NB > SB + QUO_W + 1) ? NB : SB + QUO_W + 1) + 1;

	logic [2:0][W-1:0]     rem_s  [QUO_W+1];
	logic [2:0][QUO_W-1:0] quo_s  [QUO_W+1];
	logic [2:0]            ovf_s  [QUO_W+1];
	logic [W-1:0]          dv_s   [QUO_W+1];
	logic [SB-1:0]         root_s [QUO_W+1];
	logic                  vld_s  [QUO_W+1];
	side_t                 side_s [QUO_W+1];

	logic [2:0][W-1:0] num;
	logic [W-1:0]      dv;
	logic [2:0]        big;

	// numerator |d|*one + S for round-half-up, divisor 2S
	always_comb begin
		dv = W'(root) << 1;
		for (int l = 0; l < 3; l++) begin
			num[l] = (W'(in_side.mag[l]) << FRAC_BITS) + W'(root);
			big[l] = num[l] >= (dv << QUO_W);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num;
			quo_s[0]  <= '0;
			ovf_s[0]  <= big;
			dv_s[0]   <= dv;
			root_s[0] <= root;
			side_s[0] <= in_side;
		end
	end

	// restoring division, one quotient bit per stage, msb first
	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int B = QUO_W - 1 - k;
		logic [W-1:0] dsh;
		assign dsh = dv_s[k] << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[k+1]  <= ovf_s[k];
				dv_s[k+1]   <= dv_s[k];
				root_s[k+1] <= root_s[k];
				side_s[k+1] <= side_s[k];
				for (int l = 0; l < 3; l++) begin
					if (rem_s[k][l] >= dsh) begin
						rem_s[k+1][l] <= rem_s[k][l] - dsh;
						quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], 1'b1};
					end else begin
						rem_s[k+1][l] <= rem_s[k][l];
						quo_s[k+1][l] <= {quo_s[k][l][QUO_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = quo_s[QUO_W];
	assign ovf       = ovf_s[QUO_W];
	assign out_root  = root_s[QUO_W];
	assign out_side  = side_s[QUO_W];
endmodule
`default_nettype wire

/* sv/rotation_matrix_to_quaternion_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// rotation matrix to unit quaternion, trace / largest-diagonal method, fixed point
//
// mat:  input channel, valid/ready, nine signed elements r00..r22 with
//       FRAC_BITS fraction bits (Q1.14 by default)
// quat: output channel, valid/ready, quat_x/y/z/w saturated to +-1.0 and
//       a degenerate flag (outputs zero when the radicand is not positive)
//
// the square root resolves one bit per stage and each of the three dividers
// one quotient bit per stage, and those stage counts set the depth from the
// mat transaction to quat valid.
// throughput: one transaction per cycle while quat.ready stays high.
//
// reset clears every stage valid bit; payload registers are not reset.
// when quat holds a result that is not taken, the whole pipeline freezes
// and mat.ready drops; nothing is lost or repeated.
module rotation_matrix_to_quaternion_unit
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	rmq_in_if.sink   mat,
	rmq_out_if.source quat
);
	localparam int RB  = rad_bits(FRAC_BITS);
	localparam int SB  = sqrt_bits(FRAC_BITS);
	// saturation limit min(one, 32767)
	localparam int LIM = (FRAC_BITS < 15) ? (1 << FRAC_BITS) : 32767;
	localparam logic [QUO_W-1:0] LIM_Q = QUO_W'(LIM);

	// global advance: move when the output slot is empty or being taken
	logic en;
	assign en        = !quat.valid || quat.ready;
	assign mat.ready = en;

	logic signed [2:0][2:0][DATA_W-1:0] m;
	assign m[0][0] = mat.r00;
	assign m[0][1] = mat.r01;
	assign m[0][2] = mat.r02;
	assign m[1][0] = mat.r10;
	assign m[1][1] = mat.r11;
	assign m[1][2] = mat.r12;
	assign m[2][0] = mat.r20;
	assign m[2][1] = mat.r21;
	assign m[2][2] = mat.r22;

	// stage 1: trace, axis pick, radicand, numerators
	logic          p_valid;
	logic [RB-1:0] p_rad;
	side_t         p_side;

	rmq_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mat.valid),
		.m        (m),
		.valid_s1 (p_valid),
		.rad_s1   (p_rad),
		.side_s1  (p_side)
	);

	// square root pipeline
	logic          s_valid;
	logic [SB-1:0] s_root;
	side_t         s_side;

	rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (p_valid),
		.rad       (p_rad),
		.in_side   (p_side),
		.out_valid (s_valid),
		.root      (s_root),
		.out_side  (s_side)
	);

	// three dividers in lockstep
	logic                  d_valid;
	logic [2:0][QUO_W-1:0] d_quo;
	logic [2:0]            d_ovf;
	logic [SB-1:0]         d_root;
	side_t                 d_side;

	rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_valid),
		.root      (s_root),
		.in_side   (s_side),
		.out_valid (d_valid),
		.quo       (d_quo),
		.ovf       (d_ovf),
		.out_root  (d_root),
		.out_side  (d_side)
	);

	// final stage: saturate, sign, route lanes to components
	logic        [SB:0]       half;
	logic        [QUO_W-1:0]  root_sat;
	logic        [QUO_W-1:0]  mag_sat [3];
	logic signed [3:0][15:0]  q;

	always_comb begin
		half     = (SB+1)'({1'b0, d_root} + (SB+1)'(1)) >> 1;
		root_sat = (half > (SB+1)'(LIM)) ? LIM_Q : QUO_W'(half);
		q        = '0;
		for (int l = 0; l < 3; l++) begin
			mag_sat[l] = (d_ovf[l] || d_quo[l] > LIM_Q) ? LIM_Q : d_quo[l];
			q[d_side.tgt[l]] = d_side.neg[l] ? -mag_sat[l] : mag_sat[l];
		end
		q[d_side.root_tgt] = root_sat;
		if (d_side.degen) begin
			q = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.valid <= 1'b0;
		end else if (en) begin
			quat.valid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat.quat_x     <= q[TGT_X];
			quat.quat_y     <= q[TGT_Y];
			quat.quat_z     <= q[TGT_Z];
			quat.quat_w     <= q[TGT_W];
			quat.degenerate <= d_side.degen;
		end
	end
endmodule
`default_nettype wire

/* tb/rmq_tb_if.sv */
`timescale 1ns / 1ps
// the block's own interface file is reused; this file only adds the checker's quat_t type
package rmq_tb_types;
	typedef struct {
		logic signed [15:0] x, y, z, w;
		logic               degen;
	} quat_t;
endpackage

/* tb/rmq_checker.sv */
`timescale 1ns / 1ps
module rmq_checker
	import rmq_tb_types::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic signed [15:0] m [0:8],
	input logic out_fire,
	input logic signed [15:0] qx, qy, qz, qw,
	input logic qdeg,
	output int errors,
	output int pending
);
	localparam longint ONE = 64'sd1 << 14;

	quat_t quat_expected[$];

	function automatic longint root_floor(input longint v);
		longint r;
		r = 0;
		for (int b = 31; b >= 0; b--)
			if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v)
				r = r + (64'sd1 << b);
		return r;
	endfunction

	function automatic longint round_div(input longint d, input longint s);
		longint mag, q;
		mag = (d < 0 ? -d : d) * ONE;
		q = (mag + s) / (2 * s);
		return d < 0 ? -q : q;
	endfunction

	function automatic logic signed [15:0] clamp(input longint v);
		if (v > ONE) return 16'(ONE);
		if (v < -ONE) return 16'(-ONE);
		return 16'(v);
	endfunction

	function automatic quat_t predict_quat(input logic signed [15:0] e [0:8]);
		longint a [0:2][0:2];
		longint q [0:3];
		longint tr, rad, s;
		int ax, aj, ak;
		quat_t res;
		for (int i = 0; i < 9; i++)
			a[i / 3][i % 3] = e[i];
		q = '{0, 0, 0, 0};
		res.degen = 1'b0;
		tr = a[0][0] + a[1][1] + a[2][2];
		if (tr > 0) begin
			s = root_floor((tr + ONE) * ONE);
			q[3] = (s + 1) >>> 1;
			q[0] = round_div(a[2][1] - a[1][2], s);
			q[1] = round_div(a[0][2] - a[2][0], s);
			q[2] = round_div(a[1][0] - a[0][1], s);
		end else begin
			ax = a[0][0] < a[1][1] ? (a[1][1] < a[2][2] ? 2 : 1)
				: (a[0][0] < a[2][2] ? 2 : 0);
			aj = (ax + 1) % 3;
			ak = (ax + 2) % 3;
			rad = a[ax][ax] - a[aj][aj] - a[ak][ak] + ONE;
			if (rad <= 0) begin
				res.degen = 1'b1;
			end else begin
				s = root_floor(rad * ONE);
				q[ax] = (s + 1) >>> 1;
				q[3] = round_div(a[ak][aj] - a[aj][ak], s);
				q[aj] = round_div(a[aj][ax] + a[ax][aj], s);
				q[ak] = round_div(a[ak][ax] + a[ax][ak], s);
			end
		end
		res.x = clamp(q[0]);
		res.y = clamp(q[1]);
		res.z = clamp(q[2]);
		res.w = clamp(q[3]);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	initial errors = 0;
	assign pending = quat_expected.size();

	always @(posedge clk) begin
		quat_t want;
		if (arst_n) begin
			if (in_fire)
				quat_expected.push_back(predict_quat(m));
			if (out_fire) begin
				if (quat_expected.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					want = quat_expected.pop_front();
					if (qx !== want.x) report_mismatch("quat_x", qx, want.x);
					if (qy !== want.y) report_mismatch("quat_y", qy, want.y);
					if (qz !== want.z) report_mismatch("quat_z", qz, want.z);
					if (qw !== want.w) report_mismatch("quat_w", qw, want.w);
					if (qdeg !== want.degen)
						report_mismatch("degenerate", qdeg, want.degen);
				end
			end
		end
	end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// drives matrices into the converter with random gaps and output stalls;
// the checker predicts each quaternion and compares it in order
module tb;
	import rmq_pkg::*;

	localparam int LATENCY = 35;
	localparam int RANDOM_COUNT = 1500;
	localparam int QUIET_FROM = 1200;  // no idling after this many random matrices

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic quiet = 1'b0;
	int errors, pending;
	logic signed [15:0] elems [0:8];

	rmq_in_if mat ();
	rmq_out_if quat ();

	rotation_matrix_to_quaternion_unit dut (
		.clk(clk), .arst_n(arst_n), .mat(mat.sink), .quat(quat.source)
	);

	assign elems = '{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12,
		mat.r20, mat.r21, mat.r22};

	rmq_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_fire(mat.valid && mat.ready), .m(elems),
		.out_fire(quat.valid && quat.ready),
		.qx(quat.quat_x), .qy(quat.quat_y), .qz(quat.quat_z), .qw(quat.quat_w),
		.qdeg(quat.degenerate),
		.errors(errors), .pending(pending)
	);

	always #2 clk = ~clk;

	// limit: room for 1500 matrices with their gaps and stalls, plus latency, many times over
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// receiver side: bursts of stall, then bursts of taking
	initial begin
		int n;
		quat.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 13);
			quat.ready <= quiet ? 1'b1 : 1'b1;
			repeat (n) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				quat.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
		end
	end

	// one transaction: hold valid until ready is seen at an edge
	task automatic send_matrix(input logic signed [15:0] e [0:8]);
		{mat.r00, mat.r01, mat.r02} <= {e[0], e[1], e[2]};
		{mat.r10, mat.r11, mat.r12} <= {e[3], e[4], e[5]};
		{mat.r20, mat.r21, mat.r22} <= {e[6], e[7], e[8]};
		mat.valid <= 1'b1;
		do @(posedge clk); while (!mat.ready);
	endtask

	// occasional gap between transactions
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			mat.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rnd_elem(input int mode);
		case (mode)
			0: return 16'($urandom);                      // any bit pattern
			1: return 16'($signed($urandom_range(0, 32768)) - 16384);
			default: return 16'($signed($urandom_range(0, 600)) - 300);
		endcase
	endfunction

	// rotation from a random axis and angle, built in real arithmetic
	function automatic void make_rotation(output logic signed [15:0] e [0:8]);
		real ux, uy, uz, nrm, ang, c, s, t;
		real r [0:8];
		ux = $urandom_range(0, 2000) - 1000.0;
		uy = $urandom_range(0, 2000) - 1000.0;
		uz = $urandom_range(0, 2000) - 1000.0;
		nrm = $sqrt(ux * ux + uy * uy + uz * uz) + 1e-9;
		ux /= nrm; uy /= nrm; uz /= nrm;
		ang = ($urandom_range(0, 62832) / 10000.0);
		c = $cos(ang); s = $sin(ang); t = 1.0 - c;
		r = '{t*ux*ux + c, t*ux*uy - s*uz, t*ux*uz + s*uy,
			t*ux*uy + s*uz, t*uy*uy + c, t*uy*uz - s*ux,
			t*ux*uz - s*uy, t*uy*uz + s*ux, t*uz*uz + c};
		for (int i = 0; i < 9; i++)
			e[i] = 16'($rtoi(r[i] * 16384.0) + $signed($urandom_range(0, 4)) - 2);
	endfunction

	initial begin
		logic signed [15:0] e [0:8];
		int mode;
		mat.valid = 1'b0;
		{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12} = '0;
		{mat.r20, mat.r21, mat.r22} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, the three half-turns, extremes, degenerate, ties
		send_matrix('{16384, 0, 0, 0, 16384, 0, 0, 0, 16384});
		send_matrix('{16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
		send_matrix('{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384});
		send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384});
		send_matrix('{0, -16384, 0, 16384, 0, 0, 0, 0, 16384});
		send_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0});
		send_matrix('{-16384, 0, 0, 0, -16384, 0, 0, 0, -16384});
		send_matrix('{16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384});
		send_matrix('{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768});
		send_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
		send_matrix('{32767, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767});
		send_matrix('{1, 0, 0, 0, 0, 0, 0, 0, 0});
		send_matrix('{-100, 32767, -32768, -32768, -100, 32767, 32767, -32768, -100});
		send_matrix('{-5000, 9000, 0, 9000, -5000, 0, 0, 0, -20000});
		send_matrix('{-32768, 1, -1, 1, -32768, 1, -1, 1, 0});
		send_matrix('{0, 16384, 16384, -16384, 0, 16384, 16384, -16384, 0});
		send_matrix('{-16383, 0, 0, 0, -1, 0, 0, 0, -1});

		// pause until everything has drained
		mat.valid <= 1'b0;
		while (pending != 0) @(posedge clk);

		// random: mostly proper rotations, the rest noise
		for (int n = 0; n < RANDOM_COUNT; n++) begin
			if (n == QUIET_FROM) quiet <= 1'b1;
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				make_rotation(e);
			end else begin
				for (int i = 0; i < 9; i++)
					e[i] = rnd_elem(mode - 6);
			end
			send_matrix(e);
			sender_gap();
		end
		mat.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* sim.f */
sv/rmq_pkg.sv
sv/rmq_if.sv
sv/rmq_prep.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_unit.sv
tb/rmq_tb_if.sv
tb/rmq_checker.sv
tb/tb.sv
